// ===== hdl/lgs_pkg.sv =====
// Shared types, codes, constants and the life rule for the generation step block.
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

  // Default grid limits.
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  // Field widths of the transaction payloads and configuration port.
  localparam int CMD_W   = 2;
  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;
  localparam int COUNT_W = 13;
  localparam int GEN_W   = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

  // The live count saturates at this value.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

  // B3/S23 rule.
  localparam logic [3:0] BORN_COUNT = 4'd3;
  localparam logic [3:0] KEEP_LOW   = 4'd2;
  localparam logic [3:0] KEEP_HIGH  = 4'd3;

  // Controls for the column tally chain.
  typedef struct packed {
    logic clear;
    logic add;
    logic shift;
  } tally_ctrl_t;

  function automatic logic life_next(input logic alive, input logic [3:0] n);
    if (alive) begin
      return (n >= KEEP_LOW) && (n <= KEEP_HIGH);
    end
    return n == BORN_COUNT;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lgs_row_cell.sv =====
// One row of the grid, a stage of the rotating row chain.
`timescale 1ns / 1ps
`default_nettype none

module lgs_row_cell #(
  parameter int COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift_en,
  input  wire logic [COLS-1:0] d,
  output logic      [COLS-1:0] q
);

  logic [COLS-1:0] row_r;

  // Reset leaves every cell dead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (shift_en) begin
      row_r <= d;
    end
  end

  assign q = row_r;

endmodule

`default_nettype wire

// ===== hdl/lgs_col_tally.sv =====
// Per-column live counter that also shifts toward column zero for summing.
`timescale 1ns / 1ps
`default_nettype none

module lgs_col_tally #(
  parameter int CW = 7
) (
  input  wire logic                clk,
  input  wire lgs_pkg::tally_ctrl_t ctrl,
  input  wire logic                bit_in,
  input  wire logic [CW-1:0]       shift_in,
  output logic      [CW-1:0]       q
);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clear) begin
      count_nxt = '0;
    end else if (ctrl.shift) begin
      count_nxt = shift_in;
    end else if (ctrl.add) begin
      count_nxt = count_r + CW'(bit_in);
    end
  end

  // Cleared at the start of every step, so no reset is needed.
  always_ff @(posedge clk) begin
    count_r <= count_nxt;
  end

  assign q = count_r;

endmodule

`default_nettype wire

// ===== hdl/lgs_row_eval.sv =====
// Next-generation logic for one row from its window of three rows.
`timescale 1ns / 1ps
`default_nettype none

module lgs_row_eval #(
  parameter int COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  wire logic [COLS-1:0] above,
  input  wire logic [COLS-1:0] cur,
  input  wire logic [COLS-1:0] below,
  input  wire logic [COLS-1:0] col_mask,
  input  wire logic            above_ok,
  input  wire logic            below_ok,
  input  wire logic            row_ok,
  output logic      [COLS-1:0] next_row
);

  logic [COLS+1:0] a_ext;
  logic [COLS+1:0] c_ext;
  logic [COLS+1:0] b_ext;

  // Rows outside the grid and columns beyond the width count as dead;
  // the extra zero bit at each end is the dead side boundary.
  always_comb begin
    a_ext = {1'b0, (above_ok ? above & col_mask : '0), 1'b0};
    c_ext = {1'b0, cur & col_mask, 1'b0};
    b_ext = {1'b0, (below_ok ? below & col_mask : '0), 1'b0};
  end

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    logic [3:0] n;
    assign n = 4'(a_ext[c]) + 4'(a_ext[c+1]) + 4'(a_ext[c+2])
             + 4'(c_ext[c])                  + 4'(c_ext[c+2])
             + 4'(b_ext[c]) + 4'(b_ext[c+1]) + 4'(b_ext[c+2]);
    assign next_row[c] = row_ok && col_mask[c] && lgs_pkg::life_next(c_ext[c+1], n);
  end

endmodule

`default_nettype wire

// ===== hdl/life_generation_step.sv =====
// Top level: Game of Life grid held in a rotating chain of row cells.
// A write or read rotates the row chain once and passes the finishing state before out_tvalid
// rises; a generation step also sweeps the column tallies in between. One command at a time:
// a new command is accepted only after the result of the last one has entered the output
// register, and a result still waiting there holds the block in its finishing state.
// Reset (synchronous, active low) clears all cells to dead, the sequencer counters, live
// count and generation counter to zero and sets both grid dimensions to 64.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_step #(
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  // Command channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // col[5:0], row[11:6], cell_value[12], zero fill
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // cell_alive[0], live_count[13:1],
                                       // generation[45:14], zero fill
);

  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int URW = $clog2(MAX_ROWS + 1);
  localparam int UCW = $clog2(MAX_COLS + 1);
  // Each column counter holds at most MAX_ROWS.
  localparam int CW  = $clog2(MAX_ROWS + 1);

  localparam int CMD_W   = lgs_pkg::CMD_W;
  localparam int COORD_W = lgs_pkg::COORD_W;
  localparam int CFG_W   = lgs_pkg::CFG_W;
  localparam int COUNT_W = lgs_pkg::COUNT_W;
  localparam int GEN_W   = lgs_pkg::GEN_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ROTATE = 2'd1;
  localparam logic [1:0] ST_TALLY  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // ---------------------------------------------------------------------------
  // Configuration. The user must write only while the block is idle; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] grid_width_r;
  logic [CFG_W-1:0] grid_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= lgs_pkg::CFG_DIM_RESET;
      grid_height_r <= lgs_pkg::CFG_DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lgs_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        lgs_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Dimensions in use: an oversized register value is clamped to the grid limit.
  logic [UCW-1:0] used_cols;
  logic [URW-1:0] used_rows;

  assign used_cols = (32'(grid_width_r) > 32'(MAX_COLS))  ? UCW'(MAX_COLS) :
                                                            UCW'(grid_width_r);
  assign used_rows = (32'(grid_height_r) > 32'(MAX_ROWS)) ? URW'(MAX_ROWS) :
                                                            URW'(grid_height_r);

  logic [MAX_COLS-1:0] col_mask;
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign col_mask[c] = 32'(c) < 32'(used_cols);
  end

  // ---------------------------------------------------------------------------
  // Sequencer and command registers.
  // ---------------------------------------------------------------------------
  logic [1:0]           state_r,  state_nxt;
  logic [RIW-1:0]       rcnt_r,   rcnt_nxt;
  logic [CIW-1:0]       tcnt_r,   tcnt_nxt;
  logic [COUNT_W-1:0]   sum_r,    sum_nxt;
  logic [COUNT_W-1:0]   live_total_r, live_total_nxt;
  logic [GEN_W-1:0]     gen_r,    gen_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [47:0]          out_data_r,  out_data_nxt;

  logic [CMD_W-1:0]     cmd_r;
  logic [COORD_W-1:0]   col_r;
  logic [COORD_W-1:0]   row_r;
  logic                 val_r;
  logic                 inside_r;
  logic                 alive_r;

  logic                 in_accept;
  logic                 rot_last;
  logic                 tally_last;
  logic                 row_hit;
  logic                 out_free;
  logic [CIW-1:0]       col_idx;

  // Row chain view: rows rotate toward cell zero, one per cycle while rotating.
  logic [MAX_COLS-1:0]  row_q [MAX_ROWS];
  logic [MAX_COLS-1:0]  prev_r;
  logic [MAX_COLS-1:0]  next_row;
  logic [MAX_COLS-1:0]  insert_row;
  logic [CW-1:0]        tally_q [MAX_COLS];
  logic [31:0]          sum_wide;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign rot_last   = (rcnt_r == RIW'(MAX_ROWS - 1));
  assign tally_last = (tcnt_r == CIW'(MAX_COLS - 1));
  assign out_free   = !out_valid_r || out_tready;
  assign col_idx    = CIW'(col_r);
  // The row now at cell zero is the one the command addresses.
  assign row_hit    = (32'(rcnt_r) == 32'(row_r)) && inside_r;

  // Saturating running sum of the column counters as they shift past column zero.
  assign sum_wide = 32'(sum_r) + 32'(tally_q[0]);

  always_comb begin
    state_nxt      = state_r;
    rcnt_nxt       = rcnt_r;
    tcnt_nxt       = tcnt_r;
    sum_nxt        = sum_r;
    live_total_nxt = live_total_r;
    gen_nxt        = gen_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          rcnt_nxt  = '0;
          state_nxt = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        rcnt_nxt = rcnt_r + RIW'(1);
        if (rot_last) begin
          rcnt_nxt = '0;
          if (cmd_r == lgs_pkg::CMD_STEP) begin
            tcnt_nxt  = '0;
            sum_nxt   = '0;
            state_nxt = ST_TALLY;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_TALLY: begin
        tcnt_nxt = tcnt_r + CIW'(1);
        sum_nxt  = (sum_wide > 32'(lgs_pkg::COUNT_MAX)) ? lgs_pkg::COUNT_MAX :
                                                          COUNT_W'(sum_wide);
        if (tally_last) begin
          live_total_nxt = sum_nxt;
          gen_nxt        = gen_r + GEN_W'(1);
          state_nxt      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, gen_r, live_total_r,
                           (cmd_r == lgs_pkg::CMD_READ) && alive_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rcnt_r       <= '0;
      tcnt_r       <= '0;
      sum_r        <= '0;
      live_total_r <= '0;
      gen_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rcnt_r       <= rcnt_nxt;
      tcnt_r       <= tcnt_nxt;
      sum_r        <= sum_nxt;
      live_total_r <= live_total_nxt;
      gen_r        <= gen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: captured command, read result, output data, window row.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_accept) begin
      cmd_r    <= in_tuser;
      col_r    <= in_tdata[5:0];
      row_r    <= in_tdata[11:6];
      val_r    <= in_tdata[12];
      inside_r <= (32'(in_tdata[5:0]) < 32'(used_cols)) &&
                  (32'(in_tdata[11:6]) < 32'(used_rows));
      alive_r  <= 1'b0;
      prev_r   <= '0;
    end else if (state_r == ST_ROTATE) begin
      // The original row leaving cell zero becomes the row above the next one.
      prev_r <= row_q[0];
      if (row_hit && (cmd_r == lgs_pkg::CMD_READ)) begin
        alive_r <= row_q[0][col_idx];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Row evaluation: at rotation step k, cell zero holds row k and cell one row
  // k + 1; the new row k enters the tail so that row zero is back at cell zero
  // once the revolution ends.
  // ---------------------------------------------------------------------------
  lgs_row_eval #(
    .COLS(MAX_COLS)
  ) u_eval (
    .above   (prev_r),
    .cur     (row_q[0]),
    .below   (row_q[1]),
    .col_mask(col_mask),
    .above_ok(rcnt_r != '0),
    .below_ok((32'(rcnt_r) + 32'd1) < 32'(used_rows)),
    .row_ok  (32'(rcnt_r) < 32'(used_rows)),
    .next_row(next_row)
  );

  always_comb begin
    insert_row = row_q[0];
    case (cmd_r)
      lgs_pkg::CMD_STEP: insert_row = next_row;
      lgs_pkg::CMD_WRITE: begin
        if (row_hit) begin
          insert_row[col_idx] = val_r;
        end
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_rows
    logic [MAX_COLS-1:0] d;
    if (i == MAX_ROWS - 1) begin : g_tail
      assign d = insert_row;
    end else begin : g_body
      assign d = row_q[i+1];
    end
    lgs_row_cell #(
      .COLS(MAX_COLS)
    ) u_row (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_en(state_r == ST_ROTATE),
      .d       (d),
      .q       (row_q[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Live count: each column accumulates its new live cells during the step,
  // then the counters shift toward column zero into the running sum.
  // ---------------------------------------------------------------------------
  lgs_pkg::tally_ctrl_t tally_ctrl;

  assign tally_ctrl.clear = in_accept && (in_tuser == lgs_pkg::CMD_STEP);
  assign tally_ctrl.add   = (state_r == ST_ROTATE) && (cmd_r == lgs_pkg::CMD_STEP);
  assign tally_ctrl.shift = (state_r == ST_TALLY);

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_tally
    logic [CW-1:0] shift_in;
    if (c == MAX_COLS - 1) begin : g_end
      assign shift_in = '0;
    end else begin : g_mid
      assign shift_in = tally_q[c+1];
    end
    lgs_col_tally #(
      .CW(CW)
    ) u_tally (
      .clk     (clk),
      .ctrl    (tally_ctrl),
      .bit_in  (next_row[c]),
      .shift_in(shift_in),
      .q       (tally_q[c])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The chain is aligned with row zero at cell zero whenever the block is idle.
  a_idle_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (rcnt_r == '0))
    else $error("row chain not aligned while idle");

  // A result appears only out of the finishing state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside the finishing state");

  // The generation counter moves only by one, and only at the end of a tally sweep.
  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_r != $past(gen_r)) |->
      ((gen_r == $past(gen_r) + GEN_W'(1)) && $past(state_r == ST_TALLY)))
    else $error("generation counter changed unexpectedly");

  // No new command is taken while a rotation or tally is in progress.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ROTATE) || (state_r == ST_TALLY)) |-> !in_tready)
    else $error("command accepted while busy");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the life_generation_step grid block.
`timescale 1ns / 1ps

module testbench;
  import lgs_pkg::*;

  // The command field is two bits wide; this code has no operation behind it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Longest command: one revolution of the row chain plus the column sweep.
  localparam int STEP_CYCLES = MAX_ROWS_DEF + MAX_COLS_DEF + 2;

  // One result transaction, unpacked from out_tdata.
  typedef struct packed {
    logic               alive;
    logic [COUNT_W-1:0] count;
    logic [GEN_W-1:0]   gen;
  } life_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [6:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // col[5:0], row[11:6], cell_value[12], zero fill
  logic [1:0]  in_tuser;    // command[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // cell_alive[0], live_count[13:1], generation[45:14], zero fill

  // Shadow copy of the block's state, kept in step with every accepted command.
  bit [MAX_COLS_DEF-1:0] shadow_grid [MAX_ROWS_DEF];
  bit [GEN_W-1:0]        shadow_generation;
  bit [COUNT_W-1:0]      shadow_live;
  bit [CFG_W-1:0]        shadow_width;
  bit [CFG_W-1:0]        shadow_height;

  // Results predicted for accepted commands, oldest first.
  life_result_t pending_results [$];
  life_result_t wanted_result;
  life_result_t got_result;

  int  mismatch_count = 0;
  int  command_count  = 0;   // commands that do real work (unused code excluded)
  bit  idling_on      = 1'b1;
  int  stall_left     = 0;

  life_generation_step dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Register values above the grid limit are clamped; small values are used as is.
  function automatic int cols_in_use();
    return (shadow_width > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(shadow_width);
  endfunction

  function automatic int rows_in_use();
    return (shadow_height > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(shadow_height);
  endfunction

  // Neighbors outside the grid in use are dead, and nothing wraps around.
  function automatic int live_neighbors(int r, int c, int h, int w);
    int n;
    int rr;
    int cc;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = r + dr;
        cc = c + dc;
        if ((dr != 0 || dc != 0) && rr >= 0 && rr < h && cc >= 0 && cc < w) begin
          n += int'(shadow_grid[rr][cc]);
        end
      end
    end
    return n;
  endfunction

  // One B3/S23 generation. Cells outside the grid in use come out dead, which
  // also clears anything left behind after the grid was made smaller.
  function automatic void advance_generation();
    bit [MAX_COLS_DEF-1:0] next_rows [MAX_ROWS_DEF];
    bit [COUNT_W-1:0]      total;
    int                    h;
    int                    w;
    int                    n;
    bit                    now_alive;
    bit                    next_alive;
    h = rows_in_use();
    w = cols_in_use();
    total = '0;
    for (int r = 0; r < MAX_ROWS_DEF; r++) begin
      next_rows[r] = '0;
    end
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        n = live_neighbors(r, c, h, w);
        now_alive = shadow_grid[r][c];
        next_alive = now_alive ? (n >= KEEP_LOW && n <= KEEP_HIGH) : (n == BORN_COUNT);
        next_rows[r][c] = next_alive;
        // The count saturates; only reachable with grids larger than the default.
        if (next_alive && total < COUNT_MAX) begin
          total++;
        end
      end
    end
    shadow_grid = next_rows;
    shadow_live = total;
    shadow_generation++;
  endfunction

  function automatic life_result_t predict_command(logic [CMD_W-1:0] cmd,
                                                   logic [COORD_W-1:0] col,
                                                   logic [COORD_W-1:0] row,
                                                   logic value);
    life_result_t res;
    bit           in_grid;
    in_grid = (int'(col) < cols_in_use()) && (int'(row) < rows_in_use());
    res.alive = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        // A write outside the grid in use is dropped.
        if (in_grid) begin
          shadow_grid[row][col] = value;
        end
      end
      CMD_STEP: begin
        advance_generation();
      end
      CMD_READ: begin
        if (in_grid) begin
          res.alive = shadow_grid[row][col];
        end
      end
      default: begin
        // The unused code changes nothing and reports the current counters.
      end
    endcase
    // A write does not recount; every result carries the count of the last step.
    res.count = shadow_live;
    res.gen   = shadow_generation;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(string what, life_result_t wanted, life_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("MISMATCH %s at %0t: expected alive=%0b count=%0d gen=%0d,",
               what, $realtime, wanted.alive, wanted.count, wanted.gen);
      $display("  actual alive=%0b count=%0d gen=%0d", got.alive, got.count, got.gen);
    end
  endtask

  // Every result transaction is compared against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result.alive = out_tdata[0];
      got_result.count = out_tdata[13:1];
      got_result.gen   = out_tdata[45:14];
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending", '0, got_result);
      end else begin
        wanted_result = pending_results.pop_front();
        if (got_result !== wanted_result) begin
          note_mismatch("result fields", wanted_result, got_result);
        end
      end
    end
  end

  // The receiver holds out_tready low at random while idling is on.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one command and returns at the edge where it is accepted. The valid
  // stays high so that a following command goes out without a gap; whoever waits
  // next lowers it first. Coordinates keep their low six bits.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input int col,
                              input int row, input logic value);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, value, COORD_W'(row), COORD_W'(col)};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_command(cmd, COORD_W'(col), COORD_W'(row), value));
    if (cmd != CMD_UNUSED) begin
      command_count++;
    end
  endtask

  // Holds the sender back until every outstanding result has been checked.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic write_register(input logic index, input logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (index == REG_GRID_WIDTH) begin
      shadow_width = value;
    end else begin
      shadow_height = value;
    end
  endtask

  task automatic set_grid(input int width, input int height);
    write_register(REG_GRID_WIDTH, CFG_W'(width));
    write_register(REG_GRID_HEIGHT, CFG_W'(height));
  endtask

  // Mostly a coordinate inside the grid in use, sometimes anywhere in the field.
  function automatic int pick_coord(int limit);
    if (limit == 0 || $urandom_range(0, 9) == 0) begin
      return $urandom_range(0, 63);
    end
    return $urandom_range(0, limit - 1);
  endfunction

  // Small grids keep random seeds dense enough to evolve for many generations.
  function automatic int pick_dimension();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(3, 12);
    if (roll < 88) return $urandom_range(13, 64);
    if (roll < 94) return $urandom_range(0, 2);
    return $urandom_range(65, 127);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corners, the dead boundary, a blinker and the unused command on the full grid.
  task automatic test_directed_patterns();
    send_command(CMD_READ, 0, 0, 1'b0);
    send_command(CMD_READ, 63, 63, 1'b1);
    send_command(CMD_UNUSED, 63, 63, 1'b1);
    // Isolated corner cells die; a block in the far corner survives only because
    // the boundary does not wrap.
    send_command(CMD_WRITE, 0, 0, 1'b1);
    send_command(CMD_WRITE, 63, 63, 1'b1);
    send_command(CMD_WRITE, 63, 62, 1'b1);
    send_command(CMD_WRITE, 62, 63, 1'b1);
    send_command(CMD_WRITE, 62, 62, 1'b1);
    send_command(CMD_WRITE, 63, 0, 1'b1);
    send_command(CMD_WRITE, 0, 63, 1'b1);
    send_command(CMD_READ, 0, 0, 1'b0);
    send_command(CMD_READ, 63, 63, 1'b0);
    // Horizontal blinker on row 10.
    send_command(CMD_WRITE, 9, 10, 1'b1);
    send_command(CMD_WRITE, 10, 10, 1'b1);
    send_command(CMD_WRITE, 11, 10, 1'b1);
    send_command(CMD_STEP, 0, 0, 1'b0);
    send_command(CMD_READ, 10, 9, 1'b0);
    send_command(CMD_READ, 9, 10, 1'b0);
    send_command(CMD_WRITE, 10, 10, 1'b0);
    send_command(CMD_STEP, 63, 63, 1'b1);
    send_command(CMD_READ, 62, 62, 1'b0);
    send_command(CMD_UNUSED, 0, 0, 1'b0);
  endtask

  // Grid registers at and beyond their limits, including zero and oversized values.
  task automatic test_grid_sizes();
    int dims [8] = '{0, 1, 2, 3, 64, 65, 127, 4};
    int w;
    int h;
    // Cells stranded outside a shrunken grid must be gone after one step.
    set_grid(64, 64);
    send_command(CMD_WRITE, 40, 40, 1'b1);
    send_command(CMD_WRITE, 41, 40, 1'b1);
    send_command(CMD_WRITE, 40, 41, 1'b1);
    send_command(CMD_WRITE, 41, 41, 1'b1);
    set_grid(20, 20);
    send_command(CMD_READ, 40, 40, 1'b0);
    send_command(CMD_STEP, 0, 0, 1'b0);
    set_grid(64, 64);
    send_command(CMD_READ, 40, 40, 1'b0);
    send_command(CMD_STEP, 0, 0, 1'b0);
    for (int i = 0; i < 8; i++) begin
      set_grid(dims[i], dims[(i + 3) % 8]);
      w = cols_in_use();
      h = rows_in_use();
      repeat (8) send_command(CMD_WRITE, pick_coord(w), pick_coord(h), 1'b1);
      repeat (2) send_command(CMD_STEP, $urandom, $urandom, 1'($urandom));
      repeat (4) send_command(CMD_READ, pick_coord(w), pick_coord(h), 1'($urandom));
    end
  endtask

  // Random seeds on random grids, evolved and probed; the last stretch has no idling.
  task automatic test_random_evolution();
    int w;
    int h;
    int burst;
    int roll;
    while (command_count < 1500) begin
      if (command_count > 1300) begin
        idling_on = 1'b0;
      end
      roll = $urandom_range(0, 3);
      if (roll == 0) begin
        write_register(REG_GRID_WIDTH, CFG_W'(pick_dimension()));
      end else if (roll == 1) begin
        write_register(REG_GRID_HEIGHT, CFG_W'(pick_dimension()));
      end else begin
        set_grid(pick_dimension(), pick_dimension());
      end
      w = cols_in_use();
      h = rows_in_use();
      repeat ($urandom_range(3, 40)) begin
        send_command(CMD_WRITE, pick_coord(w), pick_coord(h), $urandom_range(0, 5) != 0);
      end
      burst = $urandom_range(20, 80);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          send_command(CMD_STEP, $urandom, $urandom, 1'($urandom));
        end else if (roll < 60) begin
          send_command(CMD_READ, pick_coord(w), pick_coord(h), 1'($urandom));
        end else if (roll < 85) begin
          send_command(CMD_WRITE, pick_coord(w), pick_coord(h), 1'($urandom));
        end else if (roll < 93) begin
          send_command(CMD_UNUSED, $urandom, $urandom, 1'($urandom));
        end else begin
          // Coordinates anywhere in the field, often outside the grid in use.
          send_command($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                       $urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom));
        end
        // Now and then the sender waits for the block to run dry.
        if ($urandom_range(0, 199) == 0) begin
          drain_results();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    out_tready = 1'b1;
    // Reset state of the shadow copy: everything dead, full-size grid.
    for (int r = 0; r < MAX_ROWS_DEF; r++) begin
      shadow_grid[r] = '0;
    end
    shadow_generation = '0;
    shadow_live       = '0;
    shadow_width      = CFG_DIM_RESET;
    shadow_height     = CFG_DIM_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_patterns();
    test_grid_sizes();
    test_random_evolution();

    drain_results();
    repeat (STEP_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("life_generation_step verification clean");
    end else begin
      $display("life_generation_step verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5000000;
    $display("life_generation_step verification failed");
    $finish;
  end

endmodule
